// ===== rtl/tlbsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbsa_pkg
// Shared types and codes of the two-level bitmap slot allocator.
// ----------------------------------------------------------------------------
package tlbsa_pkg;

  // request kinds
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_INIT  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SLOT_LOG2 = 2'd0;
  localparam logic [1:0] CFG_RESERVED  = 2'd1;
  localparam logic [1:0] CFG_REGIONS   = 2'd2;
  localparam logic [1:0] CFG_MAX_ALLOC = 2'd3;

  localparam int OFFSET_W = 21;
  localparam int COUNT_W  = 16;
  localparam int SLOTS    = 64;

  // commands from controller to datapath
  typedef struct packed {
    logic cap;     // latch request offset
    logic clr;     // one clearing step
    logic a_rd;    // pick region, read its map
    logic a_wr;    // take slot, write back
    logic f_rd;    // decode offset, read map
    logic f_wr;    // release slot, write back
    logic nop;     // plain done result
  } tlbsa_cmd_t;

endpackage

// ===== rtl/tlbsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbsa_ctrl
// Request sequencer: accepts one item, steps the datapath, holds the result.
// ----------------------------------------------------------------------------
module tlbsa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  clr_last,
  output tlbsa_pkg::tlbsa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_ARD, S_AWR, S_FRD, S_FWR, S_NOP, S_OUT
  } state_t;

  state_t state;
  logic   init_pending;

  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd = '0;
    cmd.cap = (state == S_IDLE) && in_valid;
    unique case (state)
      S_CLR:   cmd.clr  = 1'b1;
      S_ARD:   cmd.a_rd = 1'b1;
      S_AWR:   cmd.a_wr = 1'b1;
      S_FRD:   cmd.f_rd = 1'b1;
      S_FWR:   cmd.f_wr = 1'b1;
      S_NOP:   cmd.nop  = 1'b1;
      default: ;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      init_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          if (clr_last) begin
            state <= init_pending ? S_NOP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_func)
              tlbsa_pkg::FUNC_ALLOC: state <= S_ARD;
              tlbsa_pkg::FUNC_FREE:  state <= S_FRD;
              tlbsa_pkg::FUNC_INIT: begin
                state        <= S_CLR;
                init_pending <= 1'b1;
              end
              default: state <= S_NOP;
            endcase
          end
        end
        S_ARD: state <= S_AWR;
        S_FRD: state <= S_FWR;
        S_AWR, S_FWR, S_NOP: begin
          state        <= S_OUT;
          out_valid    <= 1'b1;
          init_pending <= 1'b0;
        end
        S_OUT: begin
          if (out_ready) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tlbsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbsa_dp
// Datapath: slot map memory, region full maps, counter, config, result.
// ----------------------------------------------------------------------------
module tlbsa_dp #(
  parameter int REGION_SETS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tlbsa_pkg::tlbsa_cmd_t          cmd,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic [tlbsa_pkg::OFFSET_W-1:0] in_offset,
  output logic                           clr_last,
  output logic [1:0]                     res_status,
  output logic [tlbsa_pkg::OFFSET_W-1:0] res_offset,
  output logic [tlbsa_pkg::COUNT_W-1:0]  res_alloc,
  output logic                           res_empty
);

  localparam int DEPTH = REGION_SETS * tlbsa_pkg::SLOTS;
  localparam int SW    = (REGION_SETS > 1) ? $clog2(REGION_SETS) : 1;
  localparam int GW    = SW + 6;
  localparam int RW    = GW + 1;
  localparam int CW    = tlbsa_pkg::COUNT_W;
  localparam int OW    = tlbsa_pkg::OFFSET_W;

  // first set bit from the top; 64 when none
  function automatic logic [6:0] lead_zeros(input logic [63:0] w);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  // configuration
  logic [2:0]    slot_log2;
  logic [63:0]   reserved_mask;
  logic [9:0]    region_count;
  logic [CW-1:0] max_alloc;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_log2     <= 3'd3;
      reserved_mask <= '0;
      region_count  <= 10'd512;
      max_alloc     <= 16'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlbsa_pkg::CFG_SLOT_LOG2: slot_log2     <= cfg_data[2:0];
        tlbsa_pkg::CFG_RESERVED:  reserved_mask <= cfg_data;
        tlbsa_pkg::CFG_REGIONS:   region_count  <= cfg_data[9:0];
        default:                  max_alloc     <= cfg_data[CW-1:0];
      endcase
    end
  end

  // effective slot size and region count
  logic [2:0]    lg;
  logic [RW-1:0] rc_eff;
  logic [63:0]   pmask;

  always_comb begin
    if (slot_log2 < 3'd3)      lg = 3'd3;
    else if (slot_log2 > 3'd6) lg = 3'd6;
    else                       lg = slot_log2;
    if (RW'(region_count) > RW'(DEPTH) || 32'(region_count) > DEPTH) rc_eff = RW'(DEPTH);
    else                                                             rc_eff = RW'(region_count);
    pmask = {64{1'b1}} >> rc_eff[5:0];
  end

  // state
  logic [63:0]   full_map [REGION_SETS];
  logic [63:0]   mem [DEPTH];
  logic [63:0]   rd_data;
  logic [CW-1:0] count;
  logic [GW-1:0] clr_addr;

  // per-set exhausted flags and lowest open set
  logic [REGION_SETS-1:0] set_full;
  logic [SW-1:0]          sel_set;
  logic [63:0]            sel_eff;
  logic [5:0]             sel_reg;
  logic [6:0]             sel_lz;

  always_comb begin
    for (int s = 0; s < REGION_SETS; s++) begin
      set_full[s] = (32'(rc_eff) <= s * 64) || (&full_map[s])
                  || ((rc_eff >> 6) == RW'(s) && rc_eff[5:0] != 6'd0
                      && (&(full_map[s] | pmask)));
    end
    sel_set = '0;
    for (int s = REGION_SETS - 1; s >= 0; s--) begin
      if (!set_full[s]) sel_set = SW'(s);
    end
    sel_eff = full_map[sel_set];
    if (32'(rc_eff) <= 32'(sel_set) * 64) begin
      sel_eff = {64{1'b1}};
    end else if ((rc_eff >> 6) == RW'(sel_set) && rc_eff[5:0] != 6'd0) begin
      sel_eff = sel_eff | pmask;
    end
    sel_lz  = lead_zeros(~sel_eff);
    sel_reg = sel_lz[5:0];
  end

  // latched request state
  logic [OW-1:0] off_q;
  logic          go_q;
  logic [SW-1:0] set_q;
  logic [5:0]    reg_q;
  logic [5:0]    k_q;

  // free offset decode from the latched offset
  logic [OW-1:0] f_shift;
  logic [OW-1:0] f_align;
  logic [OW-7:0] f_gw;
  logic          f_ok;

  always_comb begin
    f_shift = off_q >> lg;
    f_align = off_q & ~({OW{1'b1}} << lg);
    f_gw    = f_shift[OW-1:6];
    f_ok    = (f_align == '0) && (32'(f_gw) < DEPTH) && (count != '0);
  end

  // memory port control
  logic          mem_we;
  logic [GW-1:0] mem_wa;
  logic [63:0]   mem_wd;
  logic [GW-1:0] mem_ra;
  logic [6:0]    a_lz;
  logic [63:0]   a_new;
  logic [63:0]   f_new;
  logic          f_hit;
  logic [31:0]   a_off;

  always_comb begin
    a_lz   = lead_zeros(~rd_data);
    a_new  = rd_data | (64'd1 << (~a_lz[5:0]));
    f_hit  = go_q && rd_data[~k_q];
    f_new  = rd_data & ~(64'd1 << (~k_q));
    a_off  = 32'({set_q, reg_q, a_lz[5:0]}) << lg;
    mem_we = 1'b0;
    mem_wa = {set_q, reg_q};
    mem_wd = a_new;
    if (cmd.clr) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = (clr_addr == '0) ? reserved_mask : 64'd0;
    end else if (cmd.a_wr) begin
      mem_we = go_q && !a_lz[6];
    end else if (cmd.f_wr) begin
      mem_we = f_hit;
      mem_wd = f_new;
    end
    mem_ra = cmd.a_rd ? {sel_set, sel_reg} : f_gw[GW-1:0];
  end

  assign clr_last = cmd.clr && (32'(clr_addr) == DEPTH - 1);

  // slot map memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  // request latches
  always_ff @(posedge clk) begin
    if (cmd.cap) off_q <= in_offset;
    if (cmd.a_rd) begin
      go_q  <= (count < max_alloc) && !(&set_full);
      set_q <= sel_set;
      reg_q <= sel_reg;
    end
    if (cmd.f_rd) begin
      go_q  <= f_ok;
      set_q <= f_gw[GW-1:6];
      reg_q <= f_gw[5:0];
      k_q   <= f_shift[5:0];
    end
  end

  // maps, counter and results
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      clr_addr <= '0;
      for (int s = 0; s < REGION_SETS; s++) full_map[s] <= '0;
    end else begin
      if (cmd.clr) begin
        clr_addr    <= clr_last ? '0 : clr_addr + 1'b1;
        count       <= '0;
        // header region starts full when every header slot is reserved
        full_map[0] <= {(&reserved_mask), 63'd0};
        for (int s = 1; s < REGION_SETS; s++) full_map[s] <= '0;
      end
      if (cmd.a_wr && go_q) begin
        if (a_lz[6] || (&a_new)) full_map[set_q][~reg_q] <= 1'b1;
        if (!a_lz[6]) count <= count + 1'b1;
      end
      if (cmd.f_wr && f_hit) begin
        full_map[set_q][~reg_q] <= 1'b0;
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nop) begin
      res_status <= tlbsa_pkg::ST_DONE;
      res_offset <= '0;
      res_alloc  <= count;
      res_empty  <= 1'b0;
    end
    if (cmd.a_wr) begin
      res_empty <= 1'b0;
      if (go_q && !a_lz[6]) begin
        res_status <= tlbsa_pkg::ST_DONE;
        res_offset <= a_off[OW-1:0];
        res_alloc  <= count + 1'b1;
      end else begin
        res_status <= tlbsa_pkg::ST_FULL;
        res_offset <= '0;
        res_alloc  <= count;
      end
    end
    if (cmd.f_wr) begin
      res_offset <= '0;
      if (f_hit) begin
        res_status <= tlbsa_pkg::ST_DONE;
        res_alloc  <= count - 1'b1;
        res_empty  <= (count == CW'(1));
      end else begin
        res_status <= tlbsa_pkg::ST_INVALID;
        res_alloc  <= count;
        res_empty  <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/two_level_bitmap_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_bitmap_slot_allocator
// Fixed-size slot allocator with per-region taken maps and per-set full maps.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_*: s_tuser is the kind (allocate, free, init),
//   s_tdata carries the byte offset of the slot to free. One result per
//   request leaves on m_*: m_tuser is the status, m_tdata holds the slot
//   offset, the allocation count and the now-empty flag.
//   Allocate and free each run one map read and then one write-back on
//   the slot map memory after the request is accepted and before the
//   result is handed over. One request is in flight at a time; s_tready
//   is high only when the block is idle and no result is waiting.
//   Init sweeps all REGION_SETS*64 words of the slot map memory one word
//   a cycle, then gives its result. Reset runs the same sweep with no
//   result, so s_tready rises only once the sweep has finished.
//   A stalled receiver holds the result in m_tdata/m_tuser; no new
//   request is taken until it is accepted.
//   Configuration writes on cfg_* take effect at once; write them only
//   while the block is idle.
// ----------------------------------------------------------------------------
module two_level_bitmap_slot_allocator #(
  parameter int REGION_SETS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // free_offset[20:0], zero pad
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // slot_offset[20:0], allocations[36:21], now_empty[37], pad
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  tlbsa_pkg::tlbsa_cmd_t                cmd;
  logic                                 clr_last;
  logic [1:0]                           res_status;
  logic [tlbsa_pkg::OFFSET_W-1:0]       res_offset;
  logic [tlbsa_pkg::COUNT_W-1:0]        res_alloc;
  logic                                 res_empty;

  // sequencer
  tlbsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .clr_last  (clr_last),
    .cmd       (cmd)
  );

  // maps and arithmetic
  tlbsa_dp #(
    .REGION_SETS (REGION_SETS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_offset  (s_tdata[tlbsa_pkg::OFFSET_W-1:0]),
    .clr_last   (clr_last),
    .res_status (res_status),
    .res_offset (res_offset),
    .res_alloc  (res_alloc),
    .res_empty  (res_empty)
  );

  // result packing
  assign m_tuser = res_status;
  assign m_tdata = {2'b00, res_empty, res_alloc, res_offset};

  // one request at a time: never ready while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request taken while a result waits");

  // clearing pass after reset keeps input closed
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("ready during clearing pass");

  // a full allocate returns no offset
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tlbsa_pkg::ST_FULL) |-> (m_tdata[20:0] == '0))
    else $error("offset on full status");

  // empty flag only with zero count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[37]) |-> (m_tdata[36:21] == '0))
    else $error("empty flag with allocations");

endmodule

// ===== bench/two_level_bitmap_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_bitmap_slot_allocator_tb
// Self-checking bench for the two-level bitmap slot allocator. A directed
// table covers the reset state, extreme offsets, every request kind and the
// invalid-free cases. Random phases follow under several register settings,
// mostly allocates and frees of slots known to be taken. A local allocator
// model predicts each untyped result, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module two_level_bitmap_slot_allocator_tb;

  localparam int SETS        = 8;
  localparam int REGIONS     = SETS * 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 300;

  // request kind with no action
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  st;
    logic [20:0] slot;
    logic [15:0] cnt;
    logic        emp;
  } alloc_result_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [20:0] off;
    logic        typed;
    logic [1:0]  st;
    logic [20:0] slot;
    logic [15:0] cnt;
    logic        emp;
  } dir_row_t;

  typedef struct packed {
    logic [2:0]  lg;
    logic [63:0] rsv;
    logic [9:0]  rc;
    logic [15:0] maxa;
  } phase_cfg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // free_offset[20:0], zero pad
  logic [1:0]  s_tuser = '0;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // slot_offset[20:0], allocations[36:21], now_empty[37], pad
  logic [1:0]  m_tuser;        // status[1:0]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  two_level_bitmap_slot_allocator #(.REGION_SETS(SETS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // allocator model state
  logic [63:0] taken_map [REGIONS];
  logic [63:0] full_map  [SETS];
  int unsigned alloc_cnt;
  logic [2:0]  cfg_lg;
  logic [63:0] cfg_rsv;
  logic [9:0]  cfg_rc;
  logic [15:0] cfg_maxa;

  alloc_result_t pending_q[$];
  logic [20:0]   held_offsets[$];
  int unsigned   errors, n_req, n_res, n_full, n_invalid, n_freed, cycles;
  bit            long_hold_req;

  function automatic int unsigned slot_shift();
    if (cfg_lg < 3) return 3;
    if (cfg_lg > 6) return 6;
    return cfg_lg;
  endfunction

  // full bits of a set, regions past region_count forced full
  function automatic logic [63:0] set_full_bits(int s);
    int unsigned rc, base;
    logic [63:0] beyond;
    rc = (cfg_rc > REGIONS) ? REGIONS : cfg_rc;
    base = s * 64;
    if (rc <= base) beyond = '1;
    else if (rc >= base + 64) beyond = '0;
    else beyond = (64'd1 << (64 - (rc - base))) - 64'd1;
    return full_map[s] | beyond;
  endfunction

  // index of first clear bit counting from the msb, 64 if none
  function automatic int unsigned first_clear(logic [63:0] w);
    for (int i = 0; i < 64; i++)
      if (!w[63-i]) return i;
    return 64;
  endfunction

  function automatic void clear_block();
    foreach (taken_map[i]) taken_map[i] = '0;
    foreach (full_map[i]) full_map[i] = '0;
    taken_map[0] = cfg_rsv;
    if (&cfg_rsv) full_map[0][63] = 1'b1;
    alloc_cnt = 0;
    held_offsets.delete();
  endfunction

  function automatic alloc_result_t model_request(logic [1:0] f, logic [20:0] off);
    alloc_result_t r;
    int unsigned lg, s, rg, g, k;
    logic [63:0] w;
    logic [31:0] so;
    r = '0;
    lg = slot_shift();
    case (f)
      tlbsa_pkg::FUNC_ALLOC: begin
        r.st = tlbsa_pkg::ST_FULL;
        if (alloc_cnt < cfg_maxa) begin
          s = 0;
          while (s < SETS && &set_full_bits(s)) s++;
          if (s < SETS) begin
            rg = first_clear(set_full_bits(s)) & 63;
            g = s * 64 + rg;
            w = taken_map[g];
            k = first_clear(w);
            if (k >= 64) begin
              full_map[s][63-rg] = 1'b1;
            end else begin
              w[63-k] = 1'b1;
              taken_map[g] = w;
              alloc_cnt++;
              if (&w) full_map[s][63-rg] = 1'b1;
              so = (g * 64 + k) << lg;
              r.slot = so[20:0];
              r.st = tlbsa_pkg::ST_DONE;
              held_offsets.push_back(r.slot);
            end
          end
        end
      end
      tlbsa_pkg::FUNC_FREE: begin
        g = off >> (lg + 6);
        k = (off >> lg) & 63;
        r.st = tlbsa_pkg::ST_INVALID;
        if ((off & ((21'd1 << lg) - 1)) == 0 && g < REGIONS && alloc_cnt > 0
            && taken_map[g][63-k]) begin
          taken_map[g][63-k] = 1'b0;
          full_map[g >> 6][63 - (g & 63)] = 1'b0;
          alloc_cnt--;
          r.emp = (alloc_cnt == 0);
          r.st = tlbsa_pkg::ST_DONE;
        end
      end
      tlbsa_pkg::FUNC_INIT: begin
        clear_block();
      end
      default: ;
    endcase
    r.cnt = alloc_cnt[15:0];
    return r;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int unsigned rand_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  int unsigned stall_left, hold_left;
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = rand_gap();
      m_tready <= (stall_left == 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_res++;
      if (pending_q.size() == 0) begin
        $error("result with no request pending: tuser=%0d tdata=%h", m_tuser, m_tdata);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (m_tuser !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, m_tuser);
          errors++;
        end
        if (m_tdata[20:0] !== e.slot) begin
          $error("slot_offset: expected %0d, got %0d", e.slot, m_tdata[20:0]);
          errors++;
        end
        if (m_tdata[36:21] !== e.cnt) begin
          $error("allocations: expected %0d, got %0d", e.cnt, m_tdata[36:21]);
          errors++;
        end
        if (m_tdata[37] !== e.emp) begin
          $error("now_empty: expected %0d, got %0d", e.emp, m_tdata[37]);
          errors++;
        end
        if (e.st == tlbsa_pkg::ST_FULL) n_full++;
        if (e.st == tlbsa_pkg::ST_INVALID) n_invalid++;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      tlbsa_pkg::CFG_SLOT_LOG2: cfg_lg = val[2:0];
      tlbsa_pkg::CFG_RESERVED:  cfg_rsv = val;
      tlbsa_pkg::CFG_REGIONS:   cfg_rc = val[9:0];
      default:                  cfg_maxa = val[15:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one item; typed expectation used in place of the model's when given
  task automatic send_item(logic [1:0] f, logic [20:0] off, bit typed, alloc_result_t tx);
    alloc_result_t r;
    int unsigned gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {3'b000, off};
    do @(posedge clk); while (!s_tready);
    r = model_request(f, off);
    if (f == tlbsa_pkg::FUNC_FREE && r.st == tlbsa_pkg::ST_DONE) n_freed++;
    pending_q.push_back(typed ? tx : r);
    n_req++;
    gap = rand_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  // one random request: mostly allocates and frees of held slots
  task automatic random_item();
    int unsigned p, idx;
    logic [20:0] off;
    p = $urandom_range(0, 99);
    off = 21'($urandom_range(0, 21'h1FFFFF));
    if (p < 46) begin
      send_item(tlbsa_pkg::FUNC_ALLOC, '0, 1'b0, '0);
    end else if (p < 84 && held_offsets.size() > 0) begin
      idx = $urandom_range(0, held_offsets.size() - 1);
      off = held_offsets[idx];
      held_offsets.delete(idx);
      send_item(tlbsa_pkg::FUNC_FREE, off, 1'b0, '0);
    end else if (p < 92) begin
      off = 21'($urandom_range(0, 127) << slot_shift());
      send_item(tlbsa_pkg::FUNC_FREE, off, 1'b0, '0);
    end else if (p < 96) begin
      send_item(tlbsa_pkg::FUNC_FREE, off, 1'b0, '0);
    end else if (p < 98) begin
      send_item(tlbsa_pkg::FUNC_INIT, off, 1'b0, '0);
    end else begin
      send_item(FUNC_UNUSED, off, 1'b0, '0);
    end
  endtask

  dir_row_t   dir_rows[15];
  phase_cfg_t phases[7];
  int unsigned phase_len[7];

  initial begin
    alloc_result_t tx;
    // reset defaults: 8-byte slots, no header, all regions, 32768 limit
    dir_rows = '{
      '{tlbsa_pkg::FUNC_ALLOC, 21'd0,      1'b1, tlbsa_pkg::ST_DONE,    21'd0, 16'd1, 1'b0},
      '{tlbsa_pkg::FUNC_ALLOC, 21'd0,      1'b1, tlbsa_pkg::ST_DONE,    21'd8, 16'd2, 1'b0},
      '{tlbsa_pkg::FUNC_FREE,  21'd8,      1'b1, tlbsa_pkg::ST_DONE,    21'd0, 16'd1, 1'b0},
      '{tlbsa_pkg::FUNC_FREE,  21'd8,      1'b1, tlbsa_pkg::ST_INVALID, 21'd0, 16'd1, 1'b0},
      '{tlbsa_pkg::FUNC_FREE,  21'd3,      1'b1, tlbsa_pkg::ST_INVALID, 21'd0, 16'd1, 1'b0},
      '{tlbsa_pkg::FUNC_FREE,  21'h1FFFF8, 1'b1, tlbsa_pkg::ST_INVALID, 21'd0, 16'd1, 1'b0},
      '{tlbsa_pkg::FUNC_FREE,  21'h1FFFFF, 1'b1, tlbsa_pkg::ST_INVALID, 21'd0, 16'd1, 1'b0},
      '{tlbsa_pkg::FUNC_FREE,  21'd0,      1'b1, tlbsa_pkg::ST_DONE,    21'd0, 16'd0, 1'b1},
      '{tlbsa_pkg::FUNC_FREE,  21'd0,      1'b1, tlbsa_pkg::ST_INVALID, 21'd0, 16'd0, 1'b0},
      '{FUNC_UNUSED,           21'h1FFFFF, 1'b1, tlbsa_pkg::ST_DONE,    21'd0, 16'd0, 1'b0},
      '{tlbsa_pkg::FUNC_ALLOC, 21'h1FFFFF, 1'b1, tlbsa_pkg::ST_DONE,    21'd0, 16'd1, 1'b0},
      '{tlbsa_pkg::FUNC_ALLOC, 21'd0,      1'b0, tlbsa_pkg::ST_DONE,    21'd0, 16'd0, 1'b0},
      '{tlbsa_pkg::FUNC_INIT,  21'h155555, 1'b1, tlbsa_pkg::ST_DONE,    21'd0, 16'd0, 1'b0},
      '{tlbsa_pkg::FUNC_ALLOC, 21'd0,      1'b1, tlbsa_pkg::ST_DONE,    21'd0, 16'd1, 1'b0},
      '{tlbsa_pkg::FUNC_FREE,  21'd0,      1'b0, tlbsa_pkg::ST_DONE,    21'd0, 16'd0, 1'b0}
    };
    // slot size, header mask, region count, allocation limit
    phases = '{
      '{3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 16'hFFFF},
      '{3'd0, 64'hF000_0000_0000_0001, 10'd1,    16'd32768},
      '{3'd7, 64'h0,                   10'd2,    16'd0},
      '{3'd4, 64'h8000_0000_0000_0000, 10'd0,    16'd100},
      '{3'd5, 64'h0,                   10'd65,   16'd150},
      '{3'd3, 64'h0,                   10'd512,  16'd40},
      '{3'd1, 64'h0,                   10'd3,    16'd32768}
    };
    phase_len = '{150, 170, 60, 60, 200, 180, 180};
    cfg_lg = 3'd3;
    cfg_rsv = '0;
    cfg_rc = 10'd512;
    cfg_maxa = 16'd32768;
    clear_block();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      tx = '{dir_rows[i].st, dir_rows[i].slot, dir_rows[i].cnt, dir_rows[i].emp};
      send_item(dir_rows[i].func, dir_rows[i].off, dir_rows[i].typed, tx);
    end
    wait_idle();

    // random phases under several register settings
    foreach (phases[p]) begin
      write_reg(tlbsa_pkg::CFG_SLOT_LOG2, {61'd0, phases[p].lg});
      write_reg(tlbsa_pkg::CFG_RESERVED, p == 4 ? {$urandom, $urandom} : phases[p].rsv);
      write_reg(tlbsa_pkg::CFG_REGIONS, {54'd0, phases[p].rc});
      write_reg(tlbsa_pkg::CFG_MAX_ALLOC, {48'd0, phases[p].maxa});
      send_item(tlbsa_pkg::FUNC_INIT, '0, 1'b0, '0);
      for (int n = 0; n < phase_len[p]; n++) begin
        if (p == 1 && n == 60) long_hold_req = 1'b1;
        if (p == 4 && n == 100) begin
          @(negedge clk);
          s_tvalid <= 1'b0;
          wait (pending_q.size() == 0);
        end
        random_item();
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d results: %0d full, %0d invalid, %0d frees",
             n_req, n_res, n_full, n_invalid, n_freed);
    $display("register settings visited: %0d plus reset defaults", $size(phases));
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
